/* rtl/direct_mapped_cache_hit_counter_macros.svh */
// assertion macros used by the port-level checker file
`ifndef DIRECT_MAPPED_CACHE_HIT_COUNTER_MACROS_SVH
`define DIRECT_MAPPED_CACHE_HIT_COUNTER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define DMC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmc assertion failed");

// next-cycle implication, disabled while in reset
`define DMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmc assertion failed");

`endif

/* rtl/dmc_pkg.sv */
// shared types and constants of the direct-mapped cache hit counter
`default_nettype none

package dmc_pkg;

    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 32;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_W     = 72;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_BITS  = 1'd1;

    localparam logic [CFG_W-1:0] BLOCK_BITS_RST = 4'd3;
    localparam logic [CFG_W-1:0] LINE_BITS_RST  = 4'd9;

    // controller to datapath
    typedef struct packed {
        logic clr;
        logic load;
        logic rd;
        logic upd;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

/* rtl/dmc_ram.sv */
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module dmc_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/dmc_ctrl.sv */
// sequencing state machine: clearing pass, accept, tag read, compare and update
`default_nettype none

module dmc_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire dmc_pkg::sts_t sts,
    output dmc_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_CMP   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // wait here until the result slot is free
                if (sts.out_free)
                begin
                    cmd.upd    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/dmc_datapath.sv */
// config registers, index and tag split, tag ram, hit counters and result register
`default_nettype none

module dmc_datapath #(
    parameter int MAX_LINES  = 1024,
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dmc_pkg::cmd_t                     cmd,
    output dmc_pkg::sts_t                          sts,
    input  wire logic [dmc_pkg::ADDR_W-1:0]        s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [dmc_pkg::OUT_W-1:0]         m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [dmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dmc_pkg::CFG_W-1:0]         cfg_data
);

    localparam int IDX_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int LB_MAX = $clog2(MAX_LINES + 1) - 1;
    localparam int TAG_W  = (ADDR_WIDTH < dmc_pkg::ADDR_W) ? ADDR_WIDTH : dmc_pkg::ADDR_W;
    localparam int WORD_W = TAG_W + 1;
    localparam logic [dmc_pkg::ADDR_W-1:0] ADDR_MASK = (ADDR_WIDTH >= dmc_pkg::ADDR_W) ?
        '1 : dmc_pkg::ADDR_W'((64'd1 << ADDR_WIDTH) - 64'd1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_LINES - 1);
    localparam int PAD_W  = dmc_pkg::OUT_W - 1 - 2 * dmc_pkg::CNT_W;

    logic [dmc_pkg::CFG_W-1:0]  block_bits_reg;
    logic [dmc_pkg::CFG_W-1:0]  line_bits_reg;
    logic [IDX_W-1:0]           clr_cnt_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [TAG_W-1:0]           tag_reg;
    logic [dmc_pkg::CNT_W-1:0]  hits_reg;
    logic [dmc_pkg::CNT_W-1:0]  hits_next;
    logic [dmc_pkg::CNT_W-1:0]  acc_reg;
    logic [dmc_pkg::CNT_W-1:0]  acc_next;
    logic                       hit_reg;
    logic                       m_tvalid_reg;

    logic [dmc_pkg::ADDR_W-1:0] addr_m;
    logic [4:0]                 lb_eff;
    logic [5:0]                 tag_shift;
    logic [dmc_pkg::ADDR_W-1:0] idx_full;
    logic [dmc_pkg::ADDR_W-1:0] tag_full;
    logic                       hit;

    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    logic [WORD_W-1:0]          ram_wdata;
    logic [WORD_W-1:0]          ram_rdata;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bits_reg <= dmc_pkg::BLOCK_BITS_RST;
            line_bits_reg  <= dmc_pkg::LINE_BITS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dmc_pkg::REG_BLOCK_BITS: block_bits_reg <= cfg_data;
                dmc_pkg::REG_LINE_BITS:  line_bits_reg  <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // index and tag from the incoming address
    always_comb
    begin
        addr_m    = s_tdata & ADDR_MASK;
        lb_eff    = ({1'b0, line_bits_reg} > 5'(LB_MAX)) ? 5'(LB_MAX) : {1'b0, line_bits_reg};
        tag_shift = {2'b00, block_bits_reg} + {1'b0, lb_eff};
        idx_full  = (addr_m >> block_bits_reg)
                    & ((dmc_pkg::ADDR_W'(1) << lb_eff) - dmc_pkg::ADDR_W'(1));
        tag_full  = addr_m >> tag_shift;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg <= idx_full[IDX_W-1:0];
            tag_reg <= tag_full[TAG_W-1:0];
        end
    end

    // clearing sweep over the tag ram after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr)
        begin
            clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
        end
    end

    assign sts.clr_last = (clr_cnt_reg == IDX_LAST);

    // valid bit kept in the top bit of each word
    assign ram_we    = cmd.clr | cmd.upd;
    assign ram_waddr = cmd.clr ? clr_cnt_reg : idx_reg;
    assign ram_wdata = cmd.clr ? '0 : {1'b1, tag_reg};

    dmc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_LINES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign hit = ram_rdata[TAG_W] && (ram_rdata[TAG_W-1:0] == tag_reg);

    always_comb
    begin
        hits_next = hits_reg;
        acc_next  = acc_reg;
        if (hit && (hits_reg != dmc_pkg::CNT_MAX))
        begin
            hits_next = hits_reg + dmc_pkg::CNT_W'(1);
        end
        if (acc_reg != dmc_pkg::CNT_MAX)
        begin
            acc_next = acc_reg + dmc_pkg::CNT_W'(1);
        end
    end

    // counters double as the held result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg     <= '0;
            acc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.upd)
            begin
                hits_reg     <= hits_next;
                acc_reg      <= acc_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd)
        begin
            hit_reg <= hit;
        end
    end

    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = {{PAD_W{1'b0}}, acc_reg, hits_reg, hit_reg};

endmodule

`default_nettype wire

/* rtl/direct_mapped_cache_hit_counter.sv */
// direct-mapped cache tag model with saturating hit and access counters
// after the accept, the tag ram read is registered and the compare step registers the result
// one request in flight at a time: the next is accepted only after the tag ram read-modify-write sequence
// a stalled result holds the next request in the compare step until it is taken
// reset: asynchronous; then a clearing pass over all MAX_LINES tag ram lines, no requests
// taken meanwhile; block_bits resets to 3, line_bits to 9, both counters to zero
`default_nettype none

module direct_mapped_cache_hit_counter #(
    parameter int MAX_LINES  = 1024,
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // address
    input  wire logic [dmc_pkg::ADDR_W-1:0]        s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // hit, hit_count, access_count, zero padding
    output logic      [dmc_pkg::OUT_W-1:0]         m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [dmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dmc_pkg::CFG_W-1:0]         cfg_data
);

    dmc_pkg::cmd_t cmd;
    dmc_pkg::sts_t sts;

    dmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dmc_datapath #(
        .MAX_LINES  (MAX_LINES),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

/* rtl/dmc_checker.sv */
// port-level checks for the cache hit counter and their bind
`default_nettype none

`include "direct_mapped_cache_hit_counter_macros.svh"

module dmc_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_tvalid,
    input wire logic                      s_tready,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [dmc_pkg::OUT_W-1:0] m_tdata
);

    localparam int CW = dmc_pkg::CNT_W;

    // a result stays offered until taken
    `DMC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

    // one request in flight: no accept on the cycle after an accept
    `DMC_ASSERT_NEXT(a_one_inflight, s_tvalid && s_tready, !s_tready)

    // hits never exceed accesses
    `DMC_ASSERT_NOW(a_hits_le_acc, m_tvalid, m_tdata[CW:1] <= m_tdata[2*CW:CW+1])

    // a hit means at least one hit counted
    `DMC_ASSERT_NOW(a_hit_counted, m_tvalid && m_tdata[0], m_tdata[CW:1] != '0)

endmodule

bind direct_mapped_cache_hit_counter dmc_checker u_dmc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* verif/cache_lookup_checker.sv */
`timescale 1ns / 1ps
// checker that predicts cache lookups and compares every returned result

module cache_lookup_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    // address
    input  wire logic [dmc_pkg::ADDR_W-1:0]        s_tdata,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    // hit, hit_count, access_count, zero padding
    input  wire logic [dmc_pkg::OUT_W-1:0]         m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [dmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dmc_pkg::CFG_W-1:0]         cfg_data,
    output int                                     mismatches,
    output int                                     outstanding
);

    localparam int LINES      = 1024;
    localparam int TABLE_LOG2 = $clog2(LINES);

    typedef struct packed {
        logic                      hit;
        logic [dmc_pkg::CNT_W-1:0] hit_count;
        logic [dmc_pkg::CNT_W-1:0] access_count;
    } lookup_t;

    logic [dmc_pkg::ADDR_W-1:0] line_tag [LINES];
    logic                       line_valid [LINES];
    logic [dmc_pkg::CNT_W-1:0]  hits_seen;
    logic [dmc_pkg::CNT_W-1:0]  accesses_seen;
    logic [dmc_pkg::CFG_W-1:0]  block_bits;
    logic [dmc_pkg::CFG_W-1:0]  line_bits;
    lookup_t                    lookup_q [$];
    int                         fail_cnt = 0;

    // one access: look the line up, count, then refill it with the new tag
    function automatic lookup_t access_cache(input logic [dmc_pkg::ADDR_W-1:0] addr);
        int                         lb;
        int                         idx;
        logic [dmc_pkg::ADDR_W-1:0] tag;
        lookup_t                    res;
        lb  = (line_bits > TABLE_LOG2) ? TABLE_LOG2 : int'(line_bits);
        idx = int'((addr >> block_bits) & ((32'd1 << lb) - 32'd1));
        tag = addr >> (int'(block_bits) + lb);
        res.hit = line_valid[idx] && (line_tag[idx] == tag);
        if (res.hit && hits_seen != dmc_pkg::CNT_MAX)
            hits_seen = hits_seen + 1'b1;
        if (accesses_seen != dmc_pkg::CNT_MAX)
            accesses_seen = accesses_seen + 1'b1;
        line_tag[idx]    = tag;
        line_valid[idx]  = 1'b1;
        res.hit_count    = hits_seen;
        res.access_count = accesses_seen;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        lookup_t exp_r;
        lookup_t act_r;
        if (!rst_n)
        begin
            foreach (line_valid[i])
            begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
            end
            hits_seen     = '0;
            accesses_seen = '0;
            block_bits    = dmc_pkg::BLOCK_BITS_RST;
            line_bits     = dmc_pkg::LINE_BITS_RST;
            lookup_q.delete();
        end
        else
        begin
            // results first, so a request taken at this edge cannot match one
            if (m_tvalid && m_tready)
            begin
                act_r.hit          = m_tdata[0];
                act_r.hit_count    = m_tdata[32:1];
                act_r.access_count = m_tdata[64:33];
                if (lookup_q.size() == 0)
                begin
                    fail_cnt++;
                    $display("%0t: unexpected result, expected none, %s %0d %0d %0d",
                             $time, "got hit, hits, accesses",
                             act_r.hit, act_r.hit_count, act_r.access_count);
                end
                else
                begin
                    exp_r = lookup_q.pop_front();
                    if (act_r.hit !== exp_r.hit)
                    begin
                        fail_cnt++;
                        $display("%0t: hit mismatch, expected %0d, got %0d",
                                 $time, exp_r.hit, act_r.hit);
                    end
                    if (act_r.hit_count !== exp_r.hit_count)
                    begin
                        fail_cnt++;
                        $display("%0t: hit_count mismatch, expected %0d, got %0d",
                                 $time, exp_r.hit_count, act_r.hit_count);
                    end
                    if (act_r.access_count !== exp_r.access_count)
                    begin
                        fail_cnt++;
                        $display("%0t: access_count mismatch, expected %0d, got %0d",
                                 $time, exp_r.access_count, act_r.access_count);
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == dmc_pkg::REG_BLOCK_BITS)
                    block_bits = cfg_data;
                else if (cfg_index == dmc_pkg::REG_LINE_BITS)
                    line_bits = cfg_data;
            end
            if (s_tvalid && s_tready)
                lookup_q.push_back(access_cache(s_tdata));
        end
        outstanding <= lookup_q.size();
        mismatches  <= fail_cnt;
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// top-level testbench: stimulus, result sink and verdict for the cache hit counter

module tb;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [dmc_pkg::ADDR_W-1:0]       s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [dmc_pkg::OUT_W-1:0]        m_tdata;
    logic                             cfg_we;
    logic [dmc_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [dmc_pkg::CFG_W-1:0]        cfg_data;
    int                               mismatches;
    int                               outstanding;
    int                               hold_reqs = 0;

    always #5 clk = ~clk;

    direct_mapped_cache_hit_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cache_lookup_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_address(input logic [dmc_pkg::ADDR_W-1:0] addr, input int gap);
        s_tdata  <= addr;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender stops until every request has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_geometry(input logic [3:0] blk, input logic [3:0] lines);
        cfg_we    <= 1'b1;
        cfg_index <= dmc_pkg::REG_BLOCK_BITS;
        cfg_data  <= blk;
        @(posedge clk);
        cfg_index <= dmc_pkg::REG_LINE_BITS;
        cfg_data  <= lines;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // working set of random addresses, so lines get reused and hit
    task automatic run_phase(input int n_items, input logic [3:0] blk, input logic [3:0] lines,
                             input bit long_hold);
        logic [dmc_pkg::ADDR_W-1:0] pool [16];
        logic [dmc_pkg::ADDR_W-1:0] a;
        int                         r;
        int                         k;
        bit                         tx_quiet;
        set_geometry(blk, lines);
        foreach (pool[i])
            pool[i] = $urandom;
        tx_quiet = long_hold || ($urandom_range(0, 3) == 0);
        if (long_hold)
            hold_reqs++;
        for (k = 0; k < n_items; k++)
        begin
            r = $urandom_range(0, 99);
            a = pool[$urandom_range(0, 15)];
            if (r < 70)
                a = a ^ ($urandom & ((32'd1 << blk) - 32'd1));
            else if (r < 85)
                a = a ^ (32'd1 << $urandom_range(0, 31));
            else
            begin
                a = $urandom;
                pool[$urandom_range(0, 15)] = a;
            end
            send_address(a, tx_quiet ? 0 : idle_len());
        end
        drain();
    endtask

    // result sink with random stalls and one long hold-off
    initial
    begin : sink
        int stall_left;
        int mode_left;
        int holds_done;
        bit rx_quiet;
        m_tready   = 1'b0;
        stall_left = 0;
        mode_left  = 0;
        holds_done = 0;
        rx_quiet   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                rx_quiet  = ($urandom_range(0, 2) == 0);
                mode_left = $urandom_range(100, 400);
            end
            mode_left--;
            if (hold_reqs != holds_done)
            begin
                holds_done = hold_reqs;
                stall_left = 400;
            end
            else if (stall_left == 0 && !rx_quiet && $urandom_range(0, 99) < 30)
                stall_left = idle_len();
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int p;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = dmc_pkg::REG_BLOCK_BITS;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: cold miss, repeat hit, same block, all ones, conflict eviction
        send_address(32'h0000_0000, 0);
        send_address(32'h0000_0000, 0);
        send_address(32'h0000_0004, 1);
        send_address(32'hFFFF_FFFF, 0);
        send_address(32'hFFFF_FFFF, 2);
        send_address(32'hAAAA_AAAA, 0);
        send_address(32'h5555_5555, 0);
        send_address(32'h0000_1000, 0);
        send_address(32'h0000_0000, 0);
        send_address(32'h0000_1000, 0);
        drain();

        // single line, no flush: hits on the tag left by the old geometry
        set_geometry(4'd3, 4'd0);
        send_address(32'h0000_0008, 0);
        send_address(32'h0000_0010, 0);
        send_address(32'h0000_0008, 0);
        drain();

        // largest block, line count beyond the table
        set_geometry(4'd15, 4'd15);
        send_address(32'h0000_0000, 0);
        send_address(32'h0000_8000, 0);
        send_address(32'hFFFF_FFFF, 0);
        send_address(32'h7FFF_FFFF, 0);
        send_address(32'h0200_0000, 0);
        drain();

        // byte-sized blocks over the full table
        set_geometry(4'd0, 4'd10);
        send_address(32'h0000_03FF, 0);
        send_address(32'h0000_07FF, 0);
        send_address(32'h0000_03FF, 0);
        send_address(32'h0000_0000, 0);
        send_address(32'h0000_0001, 0);
        drain();

        run_phase(130, 4'd0, 4'd0, 1'b0);
        run_phase(130, 4'd15, 4'd15, 1'b1);
        run_phase(130, 4'd12, 4'd10, 1'b0);
        run_phase(130, 4'd0, 4'd10, 1'b0);
        run_phase(130, 4'd15, 4'd0, 1'b0);
        run_phase(130, 4'd3, 4'd9, 1'b0);
        for (p = 0; p < 3; p++)
            run_phase(130, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 1'b0);

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/dmc_pkg.sv
rtl/dmc_ram.sv
rtl/dmc_ctrl.sv
rtl/dmc_datapath.sv
rtl/direct_mapped_cache_hit_counter.sv
rtl/dmc_checker.sv
verif/cache_lookup_checker.sv
verif/tb.sv
